@@ rtl/tsp_bb_pkg.sv @@
`default_nettype none
package tsp_bb_pkg;

  localparam int TOUR_W = 18;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIN_RD, ST_MIN_AC, ST_MIN_ROW, ST_INIT, ST_DISP,
    ST_EDGE, ST_DROP, ST_TEST, ST_LEAF, ST_BACK, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MIN_RD, OP_MIN_AC, OP_MIN_ROW, OP_INIT, OP_DISP_RD,
    OP_SKIP, OP_EDGE_OK, OP_DROP, OP_PUSH, OP_LEAF, OP_BACK, OP_OUT_START,
    OP_OUT_NEXT
  } dp_op_t;

  typedef struct packed {
    logic k_last;
    logic r_last;
    logic at_leaf;
    logic cand_end;
    logic edge_ok;
    logic lvl_one;
    logic take;
    logic out_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/tsp_bb_if.sv @@
`default_nettype none
interface tsp_in_if #(
  parameter int IDX_W  = 2,
  parameter int COST_W = 16
) ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  col_index;
  logic [COST_W-1:0] edge_cost;
  logic              last_entry;

  modport source (output valid, row_index, col_index, edge_cost, last_entry, input ready);
  modport sink   (input valid, row_index, col_index, edge_cost, last_entry, output ready);
endinterface

interface tsp_out_if import tsp_bb_pkg::*; #(
  parameter int IDX_W = 2
) ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  path_node;
  logic [TOUR_W-1:0] tour_cost;
  logic              found;
  logic              last_node;

  modport source (output valid, path_node, tour_cost, found, last_node, input ready);
  modport sink   (input valid, path_node, tour_cost, found, last_node, output ready);
endinterface
`default_nettype wire

@@ rtl/tsp_bb_ram.sv @@
`default_nettype none
module tsp_bb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/tsp_bb_ctrl.sv @@
`default_nettype none
module tsp_bb_ctrl import tsp_bb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_op_t        op
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid && in_last) state_nxt = ST_MIN_RD;
      ST_MIN_RD:  state_nxt = ST_MIN_AC;
      ST_MIN_AC:  state_nxt = stat.k_last ? ST_MIN_ROW : ST_MIN_RD;
      ST_MIN_ROW: state_nxt = stat.r_last ? ST_INIT : ST_MIN_RD;
      ST_INIT:    state_nxt = ST_DISP;
      ST_DISP: begin
        if (stat.at_leaf) state_nxt = ST_LEAF;
        else if (stat.cand_end) state_nxt = ST_BACK;
        else state_nxt = ST_EDGE;
      end
      ST_EDGE:    state_nxt = stat.edge_ok ? ST_DROP : ST_DISP;
      ST_DROP:    state_nxt = ST_TEST;
      ST_TEST:    state_nxt = ST_DISP;
      ST_LEAF:    state_nxt = ST_BACK;
      ST_BACK:    state_nxt = stat.lvl_one ? ST_OUT : ST_DISP;
      ST_OUT:     if (out_ready && stat.out_last) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      ST_MIN_RD:  op = OP_MIN_RD;
      ST_MIN_AC:  op = OP_MIN_AC;
      ST_MIN_ROW: op = OP_MIN_ROW;
      ST_INIT:    op = OP_INIT;
      ST_DISP:    if (stat.at_leaf || !stat.cand_end) op = OP_DISP_RD;
      ST_EDGE:    op = stat.edge_ok ? OP_EDGE_OK : OP_SKIP;
      ST_DROP:    op = OP_DROP;
      ST_TEST:    op = stat.take ? OP_PUSH : OP_SKIP;
      ST_LEAF:    op = OP_LEAF;
      ST_BACK:    op = stat.lvl_one ? OP_OUT_START : OP_BACK;
      ST_OUT:     if (out_ready) op = OP_OUT_NEXT;
      default:    op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/tsp_bb_dp.sv @@
`default_nettype none
module tsp_bb_dp import tsp_bb_pkg::*; #(
  parameter int NODES     = 4,
  parameter int COST_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_op_t                     op,
  input  wire logic [$clog2(NODES)-1:0]   row_index,
  input  wire logic [$clog2(NODES)-1:0]   col_index,
  input  wire logic [COST_BITS-1:0]       edge_cost,
  output dp_stat_t                        stat,
  output logic                            out_valid,
  output logic [$clog2(NODES)-1:0]        out_node,
  output logic [TOUR_W-1:0]               out_cost,
  output logic                            out_found,
  output logic                            out_last
);
  localparam int NB   = $clog2(NODES);
  localparam int LB   = $clog2(NODES + 1);
  localparam int AW   = $clog2(NODES * NODES);
  localparam int C    = COST_BITS;
  localparam int SUMW = C + NB + 1;
  localparam int WW   = C + LB;
  localparam int BW   = C + NB + 3;
  localparam int SW   = BW + 1;

  // row minima
  logic [NB-1:0]   r_r, k_r;
  logic [C-1:0]    lo_r, nx_r;
  logic [SUMW-1:0] sum_r;
  // search stack
  logic [LB-1:0]          lvl_r, cur_r;
  logic [LB-1:0]          cand_r   [NODES];
  logic [NB-1:0]          path_r   [NODES];
  logic signed [BW-1:0]   bound_r  [NODES];
  logic [WW-1:0]          weight_r [NODES];
  logic [NODES-1:0]       visited_r;
  logic [NB-1:0]          best_path_r [NODES];
  logic [WW-1:0]          best_cost_r;
  logic                   best_valid_r;
  logic [C-1:0]           e_r, pmin_r;
  logic signed [BW-1:0]   b_r;
  logic [WW-1:0]          w_r;
  // result register
  logic [LB-1:0]          ok_r;
  logic                   out_valid_r, out_found_r, out_last_r;
  logic [NB-1:0]          out_node_r;
  logic [TOUR_W-1:0]      out_cost_r;

  logic [C-1:0]     cost_rd;
  logic [2*C-1:0]   min_rd;
  logic             cost_we, cost_re, min_re;
  logic [AW-1:0]    cost_waddr, cost_raddr;
  logic [NB-1:0]    min_raddr;
  logic [LB-1:0]    lvl_m1, ok_nxt;
  logic [NB-1:0]    idx_m1, idx_l, prev, cur_idx;
  logic [C:0]       drop_sum;
  logic [WW-1:0]    leaf_res;
  logic signed [SW-1:0] tot;
  logic             leaf_better;

  assign lvl_m1   = lvl_r - LB'(1);
  assign idx_m1   = lvl_m1[NB-1:0];
  assign idx_l    = lvl_r[NB-1:0];
  assign prev     = path_r[idx_m1];
  assign cur_idx  = cur_r[NB-1:0];
  assign drop_sum = {1'b0, pmin_r} + {1'b0, min_rd[2*C-1:C]};
  assign leaf_res = weight_r[idx_m1] + WW'(cost_rd);
  assign tot      = $signed({b_r[BW-1], b_r}) + $signed({{(SW-WW){1'b0}}, w_r});
  assign leaf_better = (cost_rd != '0) && (!best_valid_r || leaf_res < best_cost_r);
  assign ok_nxt   = ok_r + LB'(1);

  assign cost_we    = (op == OP_LOAD) && (32'(row_index) < NODES) && (32'(col_index) < NODES);
  assign cost_waddr = AW'(row_index) * AW'(NODES) + AW'(col_index);
  assign cost_re    = (op == OP_MIN_RD) || (op == OP_DISP_RD);
  assign min_re     = (op == OP_DISP_RD) || (op == OP_EDGE_OK);
  assign min_raddr  = (op == OP_EDGE_OK) ? cur_idx : prev;

  always_comb begin
    if (op == OP_MIN_RD) begin
      cost_raddr = AW'(r_r) * AW'(NODES) + AW'(k_r);
    end else if (lvl_r == LB'(NODES)) begin
      cost_raddr = AW'(prev) * AW'(NODES);
    end else begin
      cost_raddr = AW'(prev) * AW'(NODES) + AW'(cur_idx);
    end
  end

  tsp_bb_ram #(.WIDTH(C), .DEPTH(NODES * NODES)) u_cost_ram (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(edge_cost),
    .re(cost_re), .raddr(cost_raddr), .rdata(cost_rd)
  );

  tsp_bb_ram #(.WIDTH(2 * C), .DEPTH(NODES)) u_min_ram (
    .clk(clk), .we(op == OP_MIN_ROW), .waddr(r_r), .wdata({lo_r, nx_r}),
    .re(min_re), .raddr(min_raddr), .rdata(min_rd)
  );

  always_comb begin
    stat.k_last   = (k_r == NB'(NODES - 1));
    stat.r_last   = (r_r == NB'(NODES - 1));
    stat.at_leaf  = (lvl_r == LB'(NODES));
    stat.cand_end = (cur_r == LB'(NODES));
    stat.edge_ok  = (cost_rd != '0) && !visited_r[cur_idx];
    stat.lvl_one  = (lvl_r == LB'(1));
    stat.take     = !best_valid_r || (tot < $signed({{(SW-WW){1'b0}}, best_cost_r}));
    stat.out_last = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      best_valid_r <= 1'b0;
      visited_r    <= '0;
      lvl_r        <= '0;
      cur_r        <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          r_r   <= '0;
          k_r   <= '0;
          sum_r <= '0;
          lo_r  <= '1;
          nx_r  <= '1;
        end
        OP_MIN_AC: begin
          if (k_r != r_r) begin
            if (cost_rd <= lo_r) begin
              nx_r <= lo_r;
              lo_r <= cost_rd;
            end else if (cost_rd <= nx_r && cost_rd != lo_r) begin
              nx_r <= cost_rd;
            end
          end
          k_r <= stat.k_last ? '0 : k_r + NB'(1);
        end
        OP_MIN_ROW: begin
          sum_r <= sum_r + SUMW'(lo_r) + SUMW'(nx_r);
          r_r   <= r_r + NB'(1);
          lo_r  <= '1;
          nx_r  <= '1;
        end
        OP_INIT: begin
          bound_r[0]   <= $signed(BW'((sum_r + SUMW'(1)) >> 1));
          weight_r[0]  <= '0;
          path_r[0]    <= '0;
          visited_r    <= NODES'(1);
          lvl_r        <= LB'(1);
          cur_r        <= '0;
          best_valid_r <= 1'b0;
          best_cost_r  <= '1;
        end
        OP_SKIP: cur_r <= cur_r + LB'(1);
        OP_EDGE_OK: begin
          e_r    <= cost_rd;
          pmin_r <= stat.lvl_one ? min_rd[2*C-1:C] : min_rd[C-1:0];
        end
        OP_DROP: begin
          b_r <= bound_r[idx_m1] - $signed(BW'(drop_sum[C:1]));
          w_r <= weight_r[idx_m1] + WW'(e_r);
        end
        OP_PUSH: begin
          path_r[idx_l]      <= cur_idx;
          bound_r[idx_l]     <= b_r;
          weight_r[idx_l]    <= w_r;
          cand_r[idx_l]      <= cur_r;
          visited_r[cur_idx] <= 1'b1;
          lvl_r              <= lvl_r + LB'(1);
          cur_r              <= '0;
        end
        OP_LEAF: begin
          if (leaf_better) begin
            best_path_r  <= path_r;
            best_cost_r  <= leaf_res;
            best_valid_r <= 1'b1;
          end
        end
        OP_BACK: begin
          visited_r[prev] <= 1'b0;
          cur_r           <= cand_r[idx_m1] + LB'(1);
          lvl_r           <= lvl_m1;
        end
        OP_OUT_START: begin
          ok_r        <= '0;
          out_valid_r <= 1'b1;
          out_node_r  <= best_valid_r ? best_path_r[0] : '0;
          out_cost_r  <= best_valid_r ? TOUR_W'(best_cost_r) : '0;
          out_found_r <= best_valid_r;
          out_last_r  <= !best_valid_r;
        end
        OP_OUT_NEXT: begin
          if (out_last_r) begin
            out_valid_r <= 1'b0;
          end else begin
            ok_r       <= ok_nxt;
            out_node_r <= (ok_nxt < LB'(NODES)) ? best_path_r[ok_nxt[NB-1:0]] : '0;
            out_last_r <= (ok_nxt == LB'(NODES));
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_cost  = out_cost_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;
endmodule
`default_nettype wire

@@ rtl/tsp_branch_and_bound_top.sv @@
// Travelling-salesman solver, depth-first branch and bound over a NODES x NODES matrix.
// Input channel in_ch: one matrix entry per item (row, column, cost; cost 0 = no edge).
//   An entry whose row or column is NODES or more is dropped. in_ready is high while idle.
// The item flagged last_entry stores its entry and starts the search; in_ready stays low
//   until every result of that search has been taken.
// Search: a minima pass through the single read port of the cost memory, then the tree
//   walk over branches and leaves, whose length depends on how much of the tree the
//   bound prunes.
// Result channel out_ch: NODES+1 items (tour nodes, then node 0) each carrying the cost
//   and found=1, last_node on the final one; or a single item with found=0 if no tour.
//   The result register holds an item while out_ready is low and the controller waits.
// Reset (rst_n, synchronous, active low) returns the controller to idle and drops any
//   pending result; matrix contents are kept but must be reloaded before use.
`default_nettype none
module tsp_branch_and_bound_top import tsp_bb_pkg::*; #(
  parameter int NODES     = 4,
  parameter int COST_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tsp_in_if.sink    in_ch,
  tsp_out_if.source out_ch
);
  dp_op_t   op;
  dp_stat_t stat;

  // sequencer: load, minima pass, tree walk, result emission
  tsp_bb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_last(in_ch.last_entry), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .stat(stat), .op(op)
  );

  // matrix memory, row minima, search stack and result register
  tsp_bb_dp #(.NODES(NODES), .COST_BITS(COST_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .row_index(in_ch.row_index), .col_index(in_ch.col_index), .edge_cost(in_ch.edge_cost),
    .stat(stat),
    .out_valid(out_ch.valid), .out_node(out_ch.path_node), .out_cost(out_ch.tour_cost),
    .out_found(out_ch.found), .out_last(out_ch.last_node)
  );
endmodule
`default_nettype wire

@@ rtl/tsp_bb_chk.sv @@
`default_nettype none
module tsp_bb_chk import tsp_bb_pkg::*; #(
  parameter int IDX_W = 2
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [IDX_W-1:0]  out_node,
  input wire logic [TOUR_W-1:0] out_cost,
  input wire logic              out_found,
  input wire logic              out_last
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_cost)
      && $stable(out_found) && $stable(out_last))
    else $error("stalled result changed");

  // no load while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  // no-tour result is a single cleared item
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_cost == '0 && out_node == '0)
    else $error("malformed no-tour result");

  // last entry starts the search
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready && !out_valid)
    else $error("search did not start");
endmodule

bind tsp_branch_and_bound_top tsp_bb_chk #(.IDX_W($clog2(NODES))) u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_entry),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_node(out_ch.path_node),
  .out_cost(out_ch.tour_cost), .out_found(out_ch.found), .out_last(out_ch.last_node)
);
`default_nettype wire

@@ sim/tsp_branch_and_bound_top_tb.sv @@
`timescale 1ns / 1ps

module tsp_branch_and_bound_top_tb;
  import tsp_bb_pkg::*;

  localparam int NODES     = 4;
  localparam int COST_BITS = 16;
  localparam int N_ITEMS   = 310;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 6000;
  // long receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES = 400;
  localparam longint NO_COST = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [1:0]        node;
    logic [TOUR_W-1:0] cost;
    logic              found;
    logic              last;
  } tour_item_t;

  // Tour scoreboard: mirrors the cost matrix, runs the search on every item
  // that closes a load and queues the tour items the block must return.
  class tour_scoreboard;
    logic [COST_BITS-1:0] mtx [NODES][NODES];
    int unsigned          path [NODES];
    int unsigned          best [NODES];
    longint               bnd [NODES];
    longint               wt [NODES];
    logic [NODES-1:0]     seen;
    longint               best_cost;
    bit                   best_ok;
    tour_item_t           tours_due [$];
    int                   errors;

    function new();
      errors = 0;
    endfunction

    function longint first_min(int unsigned r);
      longint m;
      m = NO_COST;
      for (int k = 0; k < NODES; k++)
        if (k != r && mtx[r][k] < m) m = mtx[r][k];
      return m;
    endfunction

    function longint second_min(int unsigned r);
      longint lo, nx, c;
      lo = NO_COST;
      nx = NO_COST;
      for (int k = 0; k < NODES; k++) begin
        if (k == r) continue;
        c = mtx[r][k];
        if (c <= lo) begin
          nx = lo;
          lo = c;
        end else if (c <= nx && c != lo) begin
          nx = c;
        end
      end
      return nx;
    endfunction

    function void descend(int unsigned lvl);
      int unsigned prev;
      longint e, w, drop, b;
      prev = path[lvl-1];
      if (lvl >= NODES) begin
        e = mtx[prev][0];
        if (e != 0 && (!best_ok || wt[NODES-1] + e < best_cost)) begin
          best      = path;
          best_cost = wt[NODES-1] + e;
          best_ok   = 1'b1;
        end
        return;
      end
      for (int unsigned c = 0; c < NODES; c++) begin
        e = mtx[prev][c];
        if (e != 0 && !seen[c]) begin
          w    = wt[lvl-1] + e;
          drop = (lvl == 1) ? (first_min(prev) + first_min(c)) / 2
                            : (second_min(prev) + first_min(c)) / 2;
          b    = bnd[lvl-1] - drop;
          // prune unless strictly below the best so far
          if (!best_ok || b + w < best_cost) begin
            path[lvl] = c;
            bnd[lvl]  = b;
            wt[lvl]   = w;
            seen[c]   = 1'b1;
            descend(lvl + 1);
            seen[c]   = 1'b0;
          end
        end
      end
    endfunction

    function void note_entry(logic [1:0] r, logic [1:0] c, logic [COST_BITS-1:0] cost,
                             logic last);
      longint sum;
      tour_item_t t;
      mtx[r][c] = cost;
      if (!last) return;
      sum = 0;
      for (int r2 = 0; r2 < NODES; r2++) sum += first_min(r2) + second_min(r2);
      for (int k = 0; k < NODES; k++) begin
        path[k] = 0;
        bnd[k]  = 0;
        wt[k]   = 0;
      end
      // fresh search: forget the previous best
      best_cost = (64'd1 << 20) - 1;
      best_ok   = 1'b0;
      bnd[0]    = (sum + 1) / 2;
      seen      = NODES'(1);
      descend(1);
      if (!best_ok) begin
        t = '{node: 2'd0, cost: '0, found: 1'b0, last: 1'b1};
        tours_due.push_back(t);
      end else begin
        for (int k = 0; k <= NODES; k++) begin
          t.node  = (k < NODES) ? best[k][1:0] : 2'd0;
          t.cost  = best_cost[TOUR_W-1:0];
          t.found = 1'b1;
          t.last  = (k == NODES);
          tours_due.push_back(t);
        end
      end
    endfunction

    function void check_tour(tour_item_t got);
      tour_item_t want;
      if (tours_due.size() == 0) begin
        $display("%0t: unexpected tour item node=%h cost=%h found=%b last=%b",
                 $time, got.node, got.cost, got.found, got.last);
        errors++;
        return;
      end
      want = tours_due.pop_front();
      if (got.node !== want.node) begin
        $display("%0t: path_node expected %h actual %h", $time, want.node, got.node);
        errors++;
      end
      if (got.cost !== want.cost) begin
        $display("%0t: tour_cost expected %h actual %h", $time, want.cost, got.cost);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %b actual %b", $time, want.found, got.found);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_node expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tsp_in_if  #(.IDX_W(2), .COST_W(COST_BITS)) in_ch ();
  tsp_out_if #(.IDX_W(2))                     out_ch ();

  tsp_branch_and_bound_top #(.NODES(NODES), .COST_BITS(COST_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tour_scoreboard sb;
  int  sent;
  int  tx_idle;
  int  rx_idle;
  bit  hold_req;
  int  quiet;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Offer one matrix entry, idling first at the current rate; hold it until taken.
  task automatic send_entry(input logic [1:0] r, input logic [1:0] c,
                            input logic [COST_BITS-1:0] cost, input logic last);
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.row_index  <= r;
    in_ch.col_index  <= c;
    in_ch.edge_cost  <= cost;
    in_ch.last_entry <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_entry(r, c, cost, last);
    sent++;
    // switch idling pattern by progress through the run
    if (sent == 120) begin
      tx_idle  = 57;
      rx_idle  = 20;
      hold_req = 1'b1;
    end else if (sent == 215) begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endtask

  // Zeros for missing edges, the extremes, repeated small values for ties.
  function automatic logic [COST_BITS-1:0] pick_cost();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1:    return '0;
      2:       return '1;
      3:       return COST_BITS'(1);
      4, 5, 6: return COST_BITS'($urandom_range(20, 1));
      default: return COST_BITS'($urandom_range(65535));
    endcase
  endfunction

  // Load the whole matrix in shuffled order, flagging the final entry.
  task automatic load_matrix();
    int order [NODES*NODES];
    int j, tmp;
    for (int i = 0; i < NODES*NODES; i++) order[i] = i;
    for (int i = NODES*NODES - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NODES*NODES; i++)
      send_entry(2'(order[i] / NODES), 2'(order[i] % NODES), pick_cost(),
                 i == NODES*NODES - 1);
  endtask

  // Receiver: random ready, with one long hold-off counted here.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Monitor: take tour items at the handshake.
  always @(posedge clk) begin
    tour_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{node: out_ch.path_node, cost: out_ch.tour_cost,
              found: out_ch.found, last: out_ch.last_node};
      sb.check_tour(got);
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tsp_branch_and_bound_top: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    sb       = new();
    sent     = 0;
    tx_idle  = 20;
    rx_idle  = 57;
    hold_req = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.row_index  <= '0;
    in_ch.col_index  <= '0;
    in_ch.edge_cost  <= '0;
    in_ch.last_entry <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every edge at full cost, diagonal zero, so the dearest tour.
    for (int i = 0; i < NODES*NODES; i++)
      send_entry(2'(i / NODES), 2'(i % NODES), (i / NODES == i % NODES) ? '0 : '1,
                 i == NODES*NODES - 1);
    // No way back to node 0: no tour.
    send_entry(2'd1, 2'd0, '0, 1'b0);
    send_entry(2'd2, 2'd0, '0, 1'b0);
    send_entry(2'd3, 2'd0, '0, 1'b1);
    // Restore the way back with ties and low costs.
    send_entry(2'd1, 2'd0, 16'd1, 1'b0);
    send_entry(2'd2, 2'd0, 16'd1, 1'b0);
    send_entry(2'd3, 2'd0, 16'd7, 1'b1);
    // A diagonal write must change nothing.
    send_entry(2'd2, 2'd2, 16'd12345, 1'b1);

    // Random: mostly small updates ending in a search, sometimes a full reload.
    while (sent < N_ITEMS) begin
      if ($urandom_range(4) == 0) begin
        load_matrix();
      end else begin
        int n;
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++)
          send_entry(2'($urandom_range(3)), 2'($urandom_range(3)), pick_cost(),
                     i == n - 1);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.tours_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tsp_branch_and_bound_top: match");
    end else begin
      $display("tsp_branch_and_bound_top: mismatch");
    end
    $finish;
  end

endmodule

@@ tsp_branch_and_bound_top.f @@
rtl/tsp_bb_pkg.sv
rtl/tsp_bb_if.sv
rtl/tsp_bb_ram.sv
rtl/tsp_bb_ctrl.sv
rtl/tsp_bb_dp.sv
rtl/tsp_branch_and_bound_top.sv
rtl/tsp_bb_chk.sv
sim/tsp_branch_and_bound_top_tb.sv
